// File: rtl/bgi_pkg.sv
// Shared widths, types and status codes for the bilinear grid interpolator.
// No dependencies; imported by every module of the block.
package bgi_pkg;

  localparam int NBR_CNT   = 4;
  localparam int NBR_IDX_W = $clog2(NBR_CNT);
  localparam int CNT_W     = $clog2(NBR_CNT + 1);

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int COL_W  = 16;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 19;
  localparam int STAT_W = 2;

  localparam int FRAC_W = 16;
  localparam int NUM_W  = 47;
  localparam int DEN_W  = 30;
  localparam int QUO_W  = 32;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 53;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SPACING = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/bgi_div.sv
// Bit-serial restoring divider: round(num * 2^16 / den), ties away from zero,
// saturated to 32 bits signed. Depends on bgi_pkg.
module bgi_div
  import bgi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DVD_W = NUM_W + FRAC_W;
  localparam int ITER_W = $clog2(DVD_W);
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(64'h7FFF_FFFF);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'h8000_0000);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_SAT} dstate_t;

  dstate_t                  state_r;
  logic                     neg_r;
  logic [NUM_W-1:0]         nabs_r;
  logic [DEN_W-1:0]         dabs_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [DEN_W-1:0]         rem_r;
  logic [ITER_W-1:0]        iter_r;
  logic                     done_r;
  logic signed [QUO_W-1:0]  quo_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dabs_r};
  assign ge     = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            neg_r   <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
            nabs_r  <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
            dabs_r  <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
            state_r <= D_PREP;
          end
        end
        D_PREP: begin
          dvd_r   <= {nabs_r, {FRAC_W{1'b0}}} + DVD_W'(dabs_r >> 1);
          rem_r   <= '0;
          iter_r  <= '0;
          state_r <= D_RUN;
        end
        D_RUN: begin
          rem_r  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          dvd_r  <= {dvd_r[DVD_W-2:0], ge};
          iter_r <= iter_r + 1'b1;
          if (iter_r == ITER_W'(DVD_W - 1)) begin
            state_r <= D_SAT;
          end
        end
        D_SAT: begin
          if (neg_r) begin
            quo_r <= (dvd_r > NEG_LIM) ? $signed(32'h8000_0000)
                                       : $signed(-dvd_r[QUO_W-1:0]);
          end else begin
            quo_r <= (dvd_r > POS_LIM) ? $signed(32'h7FFF_FFFF)
                                       : $signed(dvd_r[QUO_W-1:0]);
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/bgi_mul.sv
// Shared registered 34x34 signed multiplier, loaded when en is high.
// Depends on bgi_pkg.
module bgi_mul
  import bgi_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

// File: rtl/bilinear_grid_interpolator.sv
// Bilinear grid interpolator: a target beat, then four neighbor beats (TL, TR, BL, BR).
// A beat without the last mark leaves in_stall low. The closing beat starts a sequence of
// three fractional divisions on one bit-serial divider (63 quotient bits each, one bit a
// cycle) and ten products on one shared multiplier; input stall stays high meanwhile.
// A finished result waits in the output register while the next set loads. Depends on
// bgi_pkg, bgi_div, bgi_mul.
module bilinear_grid_interpolator
  import bgi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic signed [LAT_W-1:0]  in_lat_udeg,
  input  logic [LON_W-1:0]         in_lon_udeg,
  input  logic [COL_W-1:0]         in_col_index,
  input  logic signed [VAL_W-1:0]  in_sample_value,
  input  logic                     in_last_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VAL_W-1:0]  out_interp_value,
  output logic signed [WGT_W-1:0]  out_weight_tl,
  output logic signed [WGT_W-1:0]  out_weight_tr,
  output logic signed [WGT_W-1:0]  out_weight_bl,
  output logic signed [WGT_W-1:0]  out_weight_br,
  output logic [STAT_W-1:0]        out_status
);

  localparam logic signed [PROD_W-1:0] WMAX_P = PROD_W'(262143);
  localparam logic signed [PROD_W-1:0] WMIN_P = -PROD_W'(262144);
  localparam logic signed [ACC_W-1:0]  VMAX_A = ACC_W'(64'h7FFF_FFFF);
  localparam logic signed [ACC_W-1:0]  VMIN_A = -ACC_W'(64'h8000_0000);
  localparam logic signed [MUL_W-1:0]  ONE_M  = MUL_W'(65536);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DLAT, S_WLAT, S_DLO1, S_WLO1, S_DLO2, S_WLO2,
    S_WMUL, S_WRND, S_SMUL, S_SACC, S_FIN, S_OUT
  } state_t;

  function automatic logic signed [WGT_W-1:0] rnd_w(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = (p + (p[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768))) >>> FRAC_W;
    if (s > WMAX_P) return WMAX_P[WGT_W-1:0];
    if (s < WMIN_P) return WMIN_P[WGT_W-1:0];
    return s[WGT_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] rnd_v(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] s;
    s = (p + (p[ACC_W-1] ? ACC_W'(32767) : ACC_W'(32768))) >>> FRAC_W;
    if (s > VMAX_A) return VMAX_A[VAL_W-1:0];
    if (s < VMIN_A) return VMIN_A[VAL_W-1:0];
    return s[VAL_W-1:0];
  endfunction

  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [NBR_IDX_W-1:0]     k_r;

  logic signed [LAT_W-1:0]  target_lat_r;
  logic [LON_W-1:0]         target_lon_r;
  logic signed [LAT_W-1:0]  nbr_lat_r   [NBR_CNT];
  logic [LON_W-1:0]         nbr_lon_r   [NBR_CNT];
  logic [COL_W-1:0]         nbr_col_r   [NBR_CNT];
  logic signed [VAL_W-1:0]  nbr_value_r [NBR_CNT];

  logic signed [LAT_W:0]    dlat_r;
  logic [LON_W-1:0]         s1_r;
  logic [LON_W-1:0]         s2_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [MUL_W-1:0]  pdlat_r, pdlo1_r, pdlo2_r;
  logic signed [MUL_W-1:0]  oml_r, om1_r, om2_r;
  logic signed [WGT_W-1:0]  w_r [NBR_CNT];
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  res_value_r;
  logic [STAT_W-1:0]        res_status_r;

  logic                     out_valid_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic signed [WGT_W-1:0]  out_w_r [NBR_CNT];
  logic [STAT_W-1:0]        out_status_r;

  logic [LON_W:0]           d1, d2;
  logic [LON_W-1:0]         s1_nxt, s2_nxt;
  logic                     zero_sp;
  logic                     in_acc;
  logic                     out_free;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  quo_m;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign d1     = {1'b0, nbr_lon_r[1]} - {1'b0, nbr_lon_r[0]};
  assign d2     = {1'b0, nbr_lon_r[3]} - {1'b0, nbr_lon_r[2]};
  assign s1_nxt = d1[LON_W] ? LON_W'(-d1) : d1[LON_W-1:0];
  assign s2_nxt = d2[LON_W] ? LON_W'(-d2) : d2[LON_W-1:0];
  assign zero_sp = (nbr_lat_r[0] == nbr_lat_r[2]) || (nbr_lon_r[0] == nbr_lon_r[1]) ||
                   (nbr_lon_r[2] == nbr_lon_r[3]);

  assign quo_m = {{(MUL_W-QUO_W){div_rsp.quo[QUO_W-1]}}, div_rsp.quo};

  always_comb begin
    div_req.start = (state_r == S_DLAT) || (state_r == S_DLO1) || (state_r == S_DLO2);
    div_req.num   = num_r;
    unique case (state_r)
      S_DLAT:  div_req.den = {dlat_r[LAT_W], dlat_r};
      S_DLO1:  div_req.den = {1'b0, s1_r};
      default: div_req.den = {1'b0, s2_r};
    endcase
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_DLAT: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(nbr_col_r[0]);
        mul_b  = MUL_W'(s1_r);
      end
      S_DLO1: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(nbr_col_r[2]);
        mul_b  = MUL_W'(s2_r);
      end
      S_WMUL: begin
        mul_en = 1'b1;
        case (k_r)
          2'd0:    begin mul_a = om1_r;   mul_b = oml_r;   end
          2'd1:    begin mul_a = pdlo1_r; mul_b = oml_r;   end
          2'd2:    begin mul_a = om2_r;   mul_b = pdlat_r; end
          default: begin mul_a = pdlo2_r; mul_b = pdlat_r; end
        endcase
      end
      S_SMUL: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-WGT_W){w_r[k_r][WGT_W-1]}}, w_r[k_r]};
        mul_b  = {{(MUL_W-VAL_W){nbr_value_r[k_r][VAL_W-1]}}, nbr_value_r[k_r]};
      end
      default: ;
    endcase
  end

  bgi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bgi_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      k_r          <= '0;
      out_valid_r  <= 1'b0;
      target_lat_r <= '0;
      target_lon_r <= '0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_req_type) begin
              target_lat_r <= in_lat_udeg;
              target_lon_r <= in_lon_udeg;
              cnt_r        <= '0;
            end else if (cnt_r < CNT_W'(NBR_CNT)) begin
              nbr_lat_r[cnt_r[NBR_IDX_W-1:0]]   <= in_lat_udeg;
              nbr_lon_r[cnt_r[NBR_IDX_W-1:0]]   <= in_lon_udeg;
              nbr_col_r[cnt_r[NBR_IDX_W-1:0]]   <= in_col_index;
              nbr_value_r[cnt_r[NBR_IDX_W-1:0]] <= in_sample_value;
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_last_item) begin
              state_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          dlat_r <= {nbr_lat_r[2][LAT_W-1], nbr_lat_r[2]} -
                    {nbr_lat_r[0][LAT_W-1], nbr_lat_r[0]};
          s1_r   <= s1_nxt;
          s2_r   <= s2_nxt;
          num_r  <= {{(NUM_W-LAT_W){target_lat_r[LAT_W-1]}}, target_lat_r} -
                    {{(NUM_W-LAT_W){nbr_lat_r[0][LAT_W-1]}}, nbr_lat_r[0]};
          acc_r  <= '0;
          k_r    <= '0;
          if (cnt_r != CNT_W'(NBR_CNT) || zero_sp) begin
            res_status_r <= (cnt_r != CNT_W'(NBR_CNT)) ? STAT_MISS : STAT_SPACING;
            res_value_r  <= '0;
            for (int i = 0; i < NBR_CNT; i++) begin
              w_r[i] <= '0;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_DLAT;
          end
        end
        S_DLAT: state_r <= S_WLAT;
        S_WLAT: begin
          if (div_rsp.done) begin
            pdlat_r <= quo_m;
            oml_r   <= ONE_M - quo_m;
            num_r   <= {{(NUM_W-LON_W){1'b0}}, target_lon_r} - prod[NUM_W-1:0];
            state_r <= S_DLO1;
          end
        end
        S_DLO1: state_r <= S_WLO1;
        S_WLO1: begin
          if (div_rsp.done) begin
            pdlo1_r <= quo_m;
            om1_r   <= ONE_M - quo_m;
            num_r   <= {{(NUM_W-LON_W){1'b0}}, target_lon_r} - prod[NUM_W-1:0];
            state_r <= S_DLO2;
          end
        end
        S_DLO2: state_r <= S_WLO2;
        S_WLO2: begin
          if (div_rsp.done) begin
            pdlo2_r <= quo_m;
            om2_r   <= ONE_M - quo_m;
            state_r <= S_WMUL;
          end
        end
        S_WMUL: state_r <= S_WRND;
        S_WRND: begin
          w_r[k_r] <= rnd_w(prod);
          k_r      <= k_r + 1'b1;
          state_r  <= (k_r == NBR_IDX_W'(NBR_CNT - 1)) ? S_SMUL : S_WMUL;
        end
        S_SMUL: state_r <= S_SACC;
        S_SACC: begin
          acc_r   <= acc_r + prod[ACC_W-1:0];
          k_r     <= k_r + 1'b1;
          state_r <= (k_r == NBR_IDX_W'(NBR_CNT - 1)) ? S_FIN : S_SMUL;
        end
        S_FIN: begin
          res_value_r  <= rnd_v(acc_r);
          res_status_r <= STAT_OK;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
            for (int i = 0; i < NBR_CNT; i++) begin
              out_w_r[i] <= w_r[i];
            end
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;
  assign out_weight_tl    = out_w_r[0];
  assign out_weight_tr    = out_w_r[1];
  assign out_weight_bl    = out_w_r[2];
  assign out_weight_br    = out_w_r[3];
  assign out_status       = out_status_r;

endmodule

// File: rtl/bgi_checker.sv
// Port-level checks for the bilinear grid interpolator, bound to the top level.
// Depends on bgi_pkg and bilinear_grid_interpolator.
module bgi_checker
  import bgi_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_last_item,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [VAL_W-1:0] out_interp_value,
  input logic signed [WGT_W-1:0] out_weight_tl,
  input logic signed [WGT_W-1:0] out_weight_tr,
  input logic signed [WGT_W-1:0] out_weight_bl,
  input logic signed [WGT_W-1:0] out_weight_br,
  input logic [STAT_W-1:0]       out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_interp_value) &&
      $stable(out_weight_tl) && $stable(out_weight_tr) && $stable(out_weight_bl) &&
      $stable(out_weight_br) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_interp_value == '0 &&
      out_weight_tl == '0 && out_weight_tr == '0 && out_weight_bl == '0 &&
      out_weight_br == '0)
    else $error("error status with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_OK || out_status == STAT_MISS ||
      out_status == STAT_SPACING)
    else $error("undefined status code");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item |=> in_stall)
    else $error("closing beat did not start computation");

  a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_item |=> !in_stall)
    else $error("stalled after a loading beat");

endmodule

bind bilinear_grid_interpolator bgi_checker u_bgi_checker (.*);
